### rtl/core/mct_pkg.sv
`timescale 1ns / 1ps

package mct_pkg;

  // Default sizes of the tracked set.
  localparam int DEF_MAX_METALS = 8;
  localparam int DEF_MAX_ATOMS  = 1024;

  // Field widths of the item channels.
  localparam int SLOT_IN_W  = 3;
  localparam int ATOM_W     = 10;
  localparam int ELEM_W     = 4;
  localparam int DELTA_W    = 20;
  localparam int KIND_W     = 2;
  localparam int CNT_W      = 11;
  localparam int CFG_DATA_W = 48;
  localparam int REG_IDX_W  = 3;
  localparam int THR_W      = 24;
  localparam int SQ_W       = 2 * DELTA_W;
  localparam int D2_W       = SQ_W + 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Element codes.
  localparam logic [ELEM_W-1:0] EL_C  = 4'd1;
  localparam logic [ELEM_W-1:0] EL_O  = 4'd2;
  localparam logic [ELEM_W-1:0] EL_H  = 4'd3;
  localparam logic [ELEM_W-1:0] EL_BR = 4'd4;
  localparam logic [ELEM_W-1:0] EL_F  = 4'd5;
  localparam logic [ELEM_W-1:0] EL_S  = 4'd6;
  localparam logic [ELEM_W-1:0] EL_P  = 4'd7;
  localparam logic [ELEM_W-1:0] EL_CL = 4'd8;
  localparam logic [ELEM_W-1:0] EL_MN = 4'd9;
  localparam logic [ELEM_W-1:0] EL_RU = 4'd10;
  localparam logic [ELEM_W-1:0] EL_AU = 4'd11;

  // Event kinds.
  localparam logic [KIND_W-1:0] EV_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] EV_FORMED = 2'd1;
  localparam logic [KIND_W-1:0] EV_BROKEN = 2'd2;

  // Threshold register indexes.
  localparam int NUM_REGS = 5;
  localparam logic [REG_IDX_W-1:0] REG_MN_O_MN_H  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MN_BR_MN_F = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MN_S_MN_P  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RU_F_RU_CL = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RU_P_AU_AU = 3'd4;

  typedef logic [NUM_REGS-1:0][CFG_DATA_W-1:0] thr_regs_t;

  typedef struct packed {
    logic             hit;
    logic [THR_W-1:0] thr;
  } thr_sel_t;

  // Picks the squared threshold for an element pair; unlisted pairs miss.
  function automatic thr_sel_t thr_lookup(input logic [ELEM_W-1:0] me,
                                          input logic [ELEM_W-1:0] ae,
                                          input thr_regs_t regs);
    thr_sel_t             s;
    logic [REG_IDX_W-1:0] idx;
    logic                 high;
    s.hit = 1'b0;
    s.thr = '0;
    idx   = REG_MN_O_MN_H;
    high  = 1'b0;
    unique case (me)
      EL_MN: begin
        unique case (ae)
          EL_O:  begin s.hit = 1'b1; idx = REG_MN_O_MN_H;  high = 1'b0; end
          EL_H:  begin s.hit = 1'b1; idx = REG_MN_O_MN_H;  high = 1'b1; end
          EL_BR: begin s.hit = 1'b1; idx = REG_MN_BR_MN_F; high = 1'b0; end
          EL_F:  begin s.hit = 1'b1; idx = REG_MN_BR_MN_F; high = 1'b1; end
          EL_S:  begin s.hit = 1'b1; idx = REG_MN_S_MN_P;  high = 1'b0; end
          EL_P:  begin s.hit = 1'b1; idx = REG_MN_S_MN_P;  high = 1'b1; end
          default: s.hit = 1'b0;
        endcase
      end
      EL_RU: begin
        unique case (ae)
          EL_F:  begin s.hit = 1'b1; idx = REG_RU_F_RU_CL; high = 1'b0; end
          EL_CL: begin s.hit = 1'b1; idx = REG_RU_F_RU_CL; high = 1'b1; end
          EL_P:  begin s.hit = 1'b1; idx = REG_RU_P_AU_AU; high = 1'b0; end
          default: s.hit = 1'b0;
        endcase
      end
      EL_AU: begin
        if (ae == EL_AU) begin
          s.hit = 1'b1;
          idx   = REG_RU_P_AU_AU;
          high  = 1'b1;
        end
      end
      default: s.hit = 1'b0;
    endcase
    if (high) begin
      s.thr = regs[idx][2*THR_W-1:THR_W];
    end else begin
      s.thr = regs[idx][THR_W-1:0];
    end
    return s;
  endfunction

endpackage

### rtl/core/mct_if.sv
`timescale 1ns / 1ps

// Pair items into the tracker.
interface mct_in_if;
  logic                                valid;
  logic                                ready;
  logic [mct_pkg::SLOT_IN_W-1:0]       metal_slot;
  logic [mct_pkg::ATOM_W-1:0]          metal_atom_index;
  logic [mct_pkg::ATOM_W-1:0]          atom_index;
  logic [mct_pkg::ELEM_W-1:0]          metal_elem;
  logic [mct_pkg::ELEM_W-1:0]          atom_elem;
  logic signed [mct_pkg::DELTA_W-1:0]  delta_x;
  logic signed [mct_pkg::DELTA_W-1:0]  delta_y;
  logic signed [mct_pkg::DELTA_W-1:0]  delta_z;
  logic                                cov_bonded;
  logic                                first_snapshot;
  logic                                last_pair;

  modport source (output valid, metal_slot, metal_atom_index, atom_index, metal_elem,
                  atom_elem, delta_x, delta_y, delta_z, cov_bonded, first_snapshot,
                  last_pair, input ready);
  modport sink (input valid, metal_slot, metal_atom_index, atom_index, metal_elem,
                atom_elem, delta_x, delta_y, delta_z, cov_bonded, first_snapshot,
                last_pair, output ready);
endinterface

// Event items out of the tracker.
interface mct_out_if;
  logic                         valid;
  logic                         ready;
  logic [mct_pkg::KIND_W-1:0]   event_kind;
  logic [mct_pkg::ATOM_W-1:0]   event_metal;
  logic [mct_pkg::ATOM_W-1:0]   event_atom;
  logic [mct_pkg::CNT_W-1:0]    coord_number;
  logic                         snapshot_changed;

  modport source (output valid, event_kind, event_metal, event_atom, coord_number,
                  snapshot_changed, input ready);
  modport sink (input valid, event_kind, event_metal, event_atom, coord_number,
                snapshot_changed, output ready);
endinterface

// Threshold register writes.
interface mct_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mct_pkg::REG_IDX_W-1:0]    reg_index;
  logic [mct_pkg::CFG_DATA_W-1:0]   wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

### rtl/core/metal_contact_tracker.sv
`timescale 1ns / 1ps
// Pipeline: an accepted item passes the stage one registers, then the output register.
// Throughput: one item per cycle while results are taken and no clearing pass runs;
// the contact map memory is read at acceptance and written back as the item leaves
// stage one, with the written bit forwarded to a following item. Reset: thresholds,
// counts and the changed flag clear at once; then a clearing pass zeroes the map.
module metal_contact_tracker #(
  parameter int MAX_METALS = mct_pkg::DEF_MAX_METALS,
  parameter int MAX_ATOMS  = mct_pkg::DEF_MAX_ATOMS
) (
  input logic       clk,
  input logic       rst_n,
  mct_in_if.sink    in_if,
  mct_out_if.source out_if,
  mct_cfg_if.sink   cfg_if
);

  localparam int DEPTH  = MAX_METALS * MAX_ATOMS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SLOT_W = (MAX_METALS > 1) ? $clog2(MAX_METALS) : 1;

  // Threshold registers.
  mct_pkg::thr_regs_t thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_if.valid && cfg_if.ready &&
                 (cfg_if.reg_index < mct_pkg::REG_IDX_W'(mct_pkg::NUM_REGS))) begin
      thr_r[cfg_if.reg_index] <= cfg_if.wdata;
    end
  end

  assign cfg_if.ready = 1'b1;

  // Clearing pass over the contact map after reset.
  logic              clearing_r;
  logic [ADDR_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Handshake control.
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_fire;
  logic in_fire;

  assign s1_fire     = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !clearing_r && (!s1_valid_r || s1_fire);
  assign in_fire     = in_if.valid && in_if.ready;

  // Address of the pair in the map, and the range check.
  logic [31:0]       addr_full;
  logic [ADDR_W-1:0] rd_addr;
  logic              in_range;

  assign addr_full = 32'(in_if.metal_slot) * 32'(MAX_ATOMS) + 32'(in_if.atom_index);
  assign rd_addr   = addr_full[ADDR_W-1:0];
  assign in_range  = (32'(in_if.metal_slot) < 32'(MAX_METALS)) &&
                     (32'(in_if.atom_index) < 32'(MAX_ATOMS));

  // Stage one: item fields held while the map bit and squares come back.
  logic [mct_pkg::SLOT_IN_W-1:0] s1_slot_r;
  logic [mct_pkg::ATOM_W-1:0]    s1_midx_r;
  logic [mct_pkg::ATOM_W-1:0]    s1_aidx_r;
  logic [mct_pkg::ELEM_W-1:0]    s1_me_r;
  logic [mct_pkg::ELEM_W-1:0]    s1_ae_r;
  logic                          s1_cov_r;
  logic                          s1_first_r;
  logic                          s1_last_r;
  logic                          s1_inr_r;
  logic [ADDR_W-1:0]             s1_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_slot_r  <= in_if.metal_slot;
      s1_midx_r  <= in_if.metal_atom_index;
      s1_aidx_r  <= in_if.atom_index;
      s1_me_r    <= in_if.metal_elem;
      s1_ae_r    <= in_if.atom_elem;
      s1_cov_r   <= in_if.cov_bonded;
      s1_first_r <= in_if.first_snapshot;
      s1_last_r  <= in_if.last_pair;
      s1_inr_r   <= in_range;
      s1_addr_r  <= rd_addr;
    end
  end

  // Squared distance.
  logic [mct_pkg::D2_W-1:0] d2;

  mct_dist_sq u_dist (
    .clk (clk),
    .en  (in_fire),
    .dx  (in_if.delta_x),
    .dy  (in_if.delta_y),
    .dz  (in_if.delta_z),
    .d2  (d2)
  );

  // Contact map memory with forwarding of the bit written back alongside a read.
  logic              cmap [DEPTH];
  logic              rd_bit_r;
  logic              fwd_r;
  logic              fwd_bit_r;
  logic              map_we;
  logic              map_wbit;
  logic              new_bit;
  logic              wr_s1;
  logic [ADDR_W-1:0] map_waddr;

  assign map_we    = clearing_r || wr_s1;
  assign map_waddr = clearing_r ? clr_addr_r : s1_addr_r;
  assign map_wbit  = clearing_r ? 1'b0 : new_bit;

  always_ff @(posedge clk) begin
    if (map_we) begin
      cmap[map_waddr] <= map_wbit;
    end
    if (in_fire) begin
      rd_bit_r <= cmap[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_r     <= wr_s1 && (rd_addr == s1_addr_r);
      fwd_bit_r <= new_bit;
    end
  end

  // Contact decision and count update.
  mct_pkg::thr_sel_t           sel;
  logic                        contact;
  logic                        cur_bit;
  logic [6:0]                  slot_ext;
  logic [SLOT_W-1:0]           slot_idx;
  logic [mct_pkg::CNT_W-1:0]   coord_r [MAX_METALS];
  logic [mct_pkg::CNT_W-1:0]   cnt_cur;
  logic [mct_pkg::CNT_W-1:0]   cnt_new;
  logic [mct_pkg::CNT_W-1:0]   cn;
  logic [mct_pkg::KIND_W-1:0]  kind;
  logic                        changed_r;
  logic                        chg_any;

  assign sel      = mct_pkg::thr_lookup(s1_me_r, s1_ae_r, thr_r);
  assign contact  = (s1_midx_r != s1_aidx_r) && !s1_cov_r && (s1_ae_r != mct_pkg::EL_C) &&
                    sel.hit && (d2 <= mct_pkg::D2_W'(sel.thr));
  assign cur_bit  = fwd_r ? fwd_bit_r : rd_bit_r;
  assign slot_ext = 7'(s1_slot_r);
  assign slot_idx = slot_ext[SLOT_W-1:0];
  assign cnt_cur  = coord_r[slot_idx];

  always_comb begin
    kind    = mct_pkg::EV_NONE;
    new_bit = cur_bit;
    cnt_new = cnt_cur;
    if (s1_inr_r) begin
      if (contact && !cur_bit) begin
        kind    = mct_pkg::EV_FORMED;
        new_bit = 1'b1;
        if (cnt_cur != mct_pkg::CNT_MAX) begin
          cnt_new = cnt_cur + 1'b1;
        end
      end else if (!contact && !s1_first_r && cur_bit) begin
        kind    = mct_pkg::EV_BROKEN;
        new_bit = 1'b0;
        if (cnt_cur != '0) begin
          cnt_new = cnt_cur - 1'b1;
        end
      end
    end
  end

  assign wr_s1   = s1_fire && (kind != mct_pkg::EV_NONE);
  assign cn      = s1_inr_r ? cnt_new : '0;
  assign chg_any = changed_r || (kind != mct_pkg::EV_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_METALS; i++) begin
        coord_r[i] <= '0;
      end
    end else if (wr_s1) begin
      coord_r[slot_idx] <= cnt_new;
    end
  end

  // Changed flag, reported and cleared on the last pair of a snapshot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      changed_r <= 1'b0;
    end else if (s1_fire) begin
      changed_r <= s1_last_r ? 1'b0 : chg_any;
    end
  end

  // Output register.
  logic [mct_pkg::KIND_W-1:0] out_kind_r;
  logic [mct_pkg::ATOM_W-1:0] out_metal_r;
  logic [mct_pkg::ATOM_W-1:0] out_atom_r;
  logic [mct_pkg::CNT_W-1:0]  out_cn_r;
  logic                       out_snap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_kind_r  <= kind;
      out_metal_r <= s1_midx_r;
      out_atom_r  <= s1_aidx_r;
      out_cn_r    <= cn;
      out_snap_r  <= s1_last_r && chg_any;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.event_kind       = out_kind_r;
  assign out_if.event_metal      = out_metal_r;
  assign out_if.event_atom       = out_atom_r;
  assign out_if.coord_number     = out_cn_r;
  assign out_if.snapshot_changed = out_snap_r;

endmodule

### rtl/core/mct_dist_sq.sv
`timescale 1ns / 1ps

// Squares the three coordinate differences into registers and sums them.
module mct_dist_sq (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [mct_pkg::DELTA_W-1:0] dx,
  input  logic signed [mct_pkg::DELTA_W-1:0] dy,
  input  logic signed [mct_pkg::DELTA_W-1:0] dz,
  output logic [mct_pkg::D2_W-1:0]           d2
);

  logic signed [mct_pkg::SQ_W-1:0] px;
  logic signed [mct_pkg::SQ_W-1:0] py;
  logic signed [mct_pkg::SQ_W-1:0] pz;
  logic [mct_pkg::SQ_W-1:0]        sq_x_r;
  logic [mct_pkg::SQ_W-1:0]        sq_y_r;
  logic [mct_pkg::SQ_W-1:0]        sq_z_r;

  // A square is never negative, so its bits are taken as unsigned.
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x_r <= $unsigned(px);
      sq_y_r <= $unsigned(py);
      sq_z_r <= $unsigned(pz);
    end
  end

  // Sum of the registered squares.
  assign d2 = mct_pkg::D2_W'(sq_x_r) + mct_pkg::D2_W'(sq_y_r) + mct_pkg::D2_W'(sq_z_r);

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mct_pkg::*;

  // Cycles with no item moving on any channel before the run is abandoned.
  // The clearing pass after reset moves no item and so counts as idle.
  localparam int IDLE_LIMIT  = 50000;
  localparam int PHASE_ITEMS = 330;
  localparam int NUM_PHASES  = 6;

  localparam logic [ELEM_W-1:0] EL_OTHER  = 4'd0;
  localparam logic [ELEM_W-1:0] EL_UNUSED = 4'hF;

  localparam logic signed [DELTA_W-1:0] DELTA_MIN = {1'b1, {(DELTA_W-1){1'b0}}};
  localparam logic signed [DELTA_W-1:0] DELTA_MAX = {1'b0, {(DELTA_W-1){1'b1}}};

  // Element pairs that have a threshold, in register order, all but Ru with P.
  localparam logic [ELEM_W-1:0] LISTED_METAL [9] =
    '{EL_MN, EL_MN, EL_MN, EL_MN, EL_MN, EL_MN, EL_RU, EL_RU, EL_AU};
  localparam logic [ELEM_W-1:0] LISTED_PARTNER [9] =
    '{EL_O, EL_H, EL_BR, EL_F, EL_S, EL_P, EL_F, EL_CL, EL_AU};

  typedef struct packed {
    logic [SLOT_IN_W-1:0]       metal_slot;
    logic [ATOM_W-1:0]          metal_atom_index;
    logic [ATOM_W-1:0]          atom_index;
    logic [ELEM_W-1:0]          metal_elem;
    logic [ELEM_W-1:0]          atom_elem;
    logic signed [DELTA_W-1:0]  delta_x;
    logic signed [DELTA_W-1:0]  delta_y;
    logic signed [DELTA_W-1:0]  delta_z;
    logic                       cov_bonded;
    logic                       first_snapshot;
    logic                       last_pair;
  } pair_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ATOM_W-1:0] metal;
    logic [ATOM_W-1:0] atom;
    logic [CNT_W-1:0]  count;
    logic              changed;
  } contact_event_t;

  // Tracks contacts and counts as the block should, and holds the events still due.
  class contact_scoreboard;
    logic [CFG_DATA_W-1:0] thresholds [NUM_REGS];
    bit                    contact_map [DEF_MAX_METALS][DEF_MAX_ATOMS];
    logic [CNT_W-1:0]      coord_count [DEF_MAX_METALS];
    bit                    changed;
    contact_event_t        due_events [$];
    int                    mismatches;

    function new();
      foreach (thresholds[i]) thresholds[i] = '0;
      foreach (coord_count[i]) coord_count[i] = '0;
      foreach (contact_map[s, a]) contact_map[s][a] = 1'b0;
      changed    = 1'b0;
      mismatches = 0;
    endfunction

    function void set_threshold(int idx, logic [CFG_DATA_W-1:0] value);
      thresholds[idx] = value;
    endfunction

    function int pending();
      return due_events.size();
    endfunction

    // Works out the event that an accepted pair causes and updates the tracked state.
    function void note_pair(pair_t p);
      contact_event_t       ev;
      logic [REG_IDX_W-1:0] idx;
      logic [THR_W-1:0]     thr;
      bit                   hit;
      bit                   high;
      bit                   contact;
      longint               dx;
      longint               dy;
      longint               dz;
      longint               dist2;
      ev       = '0;
      ev.metal = p.metal_atom_index;
      ev.atom  = p.atom_index;
      hit      = 1'b0;
      high     = 1'b0;
      idx      = REG_MN_O_MN_H;

      // Choose the register and half for this element pair.
      case (p.metal_elem)
        EL_MN: begin
          hit = 1'b1;
          case (p.atom_elem)
            EL_O: idx = REG_MN_O_MN_H;
            EL_H: begin
              idx  = REG_MN_O_MN_H;
              high = 1'b1;
            end
            EL_BR: idx = REG_MN_BR_MN_F;
            EL_F: begin
              idx  = REG_MN_BR_MN_F;
              high = 1'b1;
            end
            EL_S: idx = REG_MN_S_MN_P;
            EL_P: begin
              idx  = REG_MN_S_MN_P;
              high = 1'b1;
            end
            default: hit = 1'b0;
          endcase
        end
        EL_RU: begin
          hit = 1'b1;
          case (p.atom_elem)
            EL_F: idx = REG_RU_F_RU_CL;
            EL_CL: begin
              idx  = REG_RU_F_RU_CL;
              high = 1'b1;
            end
            EL_P: idx = REG_RU_P_AU_AU;
            default: hit = 1'b0;
          endcase
        end
        EL_AU: begin
          hit  = (p.atom_elem == EL_AU);
          idx  = REG_RU_P_AU_AU;
          high = 1'b1;
        end
        default: hit = 1'b0;
      endcase
      thr = high ? thresholds[idx][2*THR_W-1:THR_W] : thresholds[idx][THR_W-1:0];

      // Squared distance against the squared threshold.
      dx      = $signed(p.delta_x);
      dy      = $signed(p.delta_y);
      dz      = $signed(p.delta_z);
      dist2   = dx * dx + dy * dy + dz * dz;
      contact = hit && (p.metal_atom_index != p.atom_index) && !p.cov_bonded &&
                (p.atom_elem != EL_C) && (dist2 <= longint'(thr));

      // Update the map and the count; breaks are held back in the first snapshot.
      if (p.metal_slot < DEF_MAX_METALS && p.atom_index < DEF_MAX_ATOMS) begin
        if (contact && !contact_map[p.metal_slot][p.atom_index]) begin
          contact_map[p.metal_slot][p.atom_index] = 1'b1;
          if (coord_count[p.metal_slot] != CNT_MAX) begin
            coord_count[p.metal_slot]++;
          end
          changed = 1'b1;
          ev.kind = EV_FORMED;
        end else if (!contact && !p.first_snapshot &&
                     contact_map[p.metal_slot][p.atom_index]) begin
          contact_map[p.metal_slot][p.atom_index] = 1'b0;
          if (coord_count[p.metal_slot] != '0) begin
            coord_count[p.metal_slot]--;
          end
          changed = 1'b1;
          ev.kind = EV_BROKEN;
        end
        ev.count = coord_count[p.metal_slot];
      end

      // The last pair of a snapshot reports and clears the changed flag.
      if (p.last_pair) begin
        ev.changed = changed;
        changed    = 1'b0;
      end
      due_events.push_back(ev);
    endfunction

    // Compares a result item with the oldest event still due.
    function void check_event(contact_event_t got);
      contact_event_t want;
      if (due_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: kind %0d metal %0d atom %0d count %0d changed %0b",
                   got.kind, got.metal, got.atom, got.count, got.changed);
        end
        return;
      end
      want = due_events.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch: expected kind %0d metal %0d atom %0d count %0d changed %0b",
                   want.kind, want.metal, want.atom, want.count, want.changed);
          $display("                 got      kind %0d metal %0d atom %0d count %0d changed %0b",
                   got.kind, got.metal, got.atom, got.count, got.changed);
        end
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  bit                steady;
  int                idle_cycles;
  contact_scoreboard sb;

  mct_in_if  in_if ();
  mct_out_if out_if ();
  mct_cfg_if cfg_if ();

  metal_contact_tracker i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic pair_t mk_pair(input logic [SLOT_IN_W-1:0] slot,
                                    input logic [ATOM_W-1:0] midx, input logic [ATOM_W-1:0] aidx,
                                    input logic [ELEM_W-1:0] me, input logic [ELEM_W-1:0] ae,
                                    input logic signed [DELTA_W-1:0] d,
                                    input logic cov, input logic first, input logic last);
    pair_t p;
    p.metal_slot       = slot;
    p.metal_atom_index = midx;
    p.atom_index       = aidx;
    p.metal_elem       = me;
    p.atom_elem        = ae;
    p.delta_x          = d;
    p.delta_y          = d;
    p.delta_z          = d;
    p.cov_bonded       = cov;
    p.first_snapshot   = first;
    p.last_pair        = last;
    return p;
  endfunction

  // Mostly small offsets around the threshold, with zeros and full-range values mixed in.
  function automatic logic signed [DELTA_W-1:0] rand_delta(input int unsigned span);
    int unsigned               pick;
    logic signed [DELTA_W-1:0] d;
    pick = $urandom_range(0, 15);
    if (pick == 0) begin
      d = '0;
    end else if (pick == 1) begin
      d = DELTA_W'($urandom);
    end else begin
      d = DELTA_W'($urandom_range(0, span));
      if ($urandom_range(0, 1) == 1) begin
        d = -d;
      end
    end
    return d;
  endfunction

  // Offers one pair item, idling at random first unless steady, and notes it once accepted.
  task automatic send_pair(input pair_t p);
    while (!steady && $urandom_range(0, 99) < 9) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid            <= 1'b1;
    in_if.metal_slot       <= p.metal_slot;
    in_if.metal_atom_index <= p.metal_atom_index;
    in_if.atom_index       <= p.atom_index;
    in_if.metal_elem       <= p.metal_elem;
    in_if.atom_elem        <= p.atom_elem;
    in_if.delta_x          <= p.delta_x;
    in_if.delta_y          <= p.delta_y;
    in_if.delta_z          <= p.delta_z;
    in_if.cov_bonded       <= p.cov_bonded;
    in_if.first_snapshot   <= p.first_snapshot;
    in_if.last_pair        <= p.last_pair;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_pair(p);
  endtask

  // Stops offering items and waits until every event due has come out.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The result side stalls at random except during the steady stretch.
  always @(posedge clk) begin
    out_if.ready <= steady || ($urandom_range(0, 99) >= 9);
  end

  // Check every accepted result item.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_event({out_if.event_kind, out_if.event_metal, out_if.event_atom,
                      out_if.coord_number, out_if.snapshot_changed});
    end
  end

  // Watchdog on cycles in which no item moves on any channel.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("FAIL metal_contact_tracker");
      $finish;
    end
  end

  initial begin
    pair_t          directed [$];
    pair_t          pool [24];
    pair_t          p;
    thr_regs_t      vals;
    int unsigned    spans [NUM_PHASES];
    int unsigned    span;
    int unsigned    sel;
    longint         lim;
    int             pool_size;
    int             cut;
    int             phase_items;
    bit             first;

    sb          = new();
    spans       = '{1, 2364, 40, 400, 1200, 2364};
    idle_cycles = 0;
    steady      = 1'b0;
    rst_n       = 1'b0;
    in_if.valid            = 1'b0;
    in_if.metal_slot       = '0;
    in_if.metal_atom_index = '0;
    in_if.atom_index       = '0;
    in_if.metal_elem       = '0;
    in_if.atom_elem        = '0;
    in_if.delta_x          = '0;
    in_if.delta_y          = '0;
    in_if.delta_z          = '0;
    in_if.cov_bonded       = 1'b0;
    in_if.first_snapshot   = 1'b0;
    in_if.last_pair        = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.reg_index       = REG_MN_O_MN_H;
    cfg_if.wdata           = '0;
    out_if.ready           = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items at the reset thresholds of zero: only a zero offset is in reach.
    // Every listed element pair forms a contact.
    directed.push_back(mk_pair(0, 5, 6, EL_MN, EL_O, 0, 0, 0, 0));
    directed.push_back(mk_pair(1, 7, 8, EL_MN, EL_H, 0, 0, 0, 0));
    directed.push_back(mk_pair(2, 9, 10, EL_MN, EL_BR, 0, 0, 0, 0));
    directed.push_back(mk_pair(3, 11, 12, EL_MN, EL_F, 0, 0, 0, 0));
    directed.push_back(mk_pair(4, 13, 14, EL_MN, EL_S, 0, 0, 0, 0));
    directed.push_back(mk_pair(5, 15, 16, EL_MN, EL_P, 0, 0, 0, 0));
    directed.push_back(mk_pair(6, 17, 18, EL_RU, EL_F, 0, 0, 0, 0));
    directed.push_back(mk_pair(7, 1023, 0, EL_RU, EL_CL, 0, 0, 0, 0));
    directed.push_back(mk_pair(7, 0, 1023, EL_RU, EL_P, 0, 0, 0, 0));
    directed.push_back(mk_pair(7, 100, 101, EL_AU, EL_AU, 0, 0, 0, 1));
    // Carbon partners, unlisted pairs, the metal itself and bonded pairs never touch.
    directed.push_back(mk_pair(0, 5, 20, EL_MN, EL_C, 0, 0, 0, 0));
    directed.push_back(mk_pair(0, 5, 21, EL_RU, EL_O, 0, 0, 0, 0));
    directed.push_back(mk_pair(0, 5, 22, EL_UNUSED, EL_UNUSED, 0, 0, 0, 0));
    directed.push_back(mk_pair(0, 5, 23, EL_OTHER, EL_MN, 0, 0, 0, 0));
    directed.push_back(mk_pair(0, 30, 30, EL_MN, EL_O, 0, 0, 0, 0));
    directed.push_back(mk_pair(0, 31, 32, EL_MN, EL_O, 0, 1, 0, 0));
    // A lost contact is held in the first snapshot and broken afterwards.
    directed.push_back(mk_pair(0, 5, 6, EL_MN, EL_O, DELTA_MIN, 0, 1, 0));
    directed.push_back(mk_pair(0, 5, 6, EL_MN, EL_O, DELTA_MIN, 0, 0, 0));
    directed.push_back(mk_pair(7, 1023, 0, EL_RU, EL_CL, DELTA_MAX, 0, 0, 0));
    directed.push_back(mk_pair(7, 0, 1023, EL_RU, EL_P, 0, 1, 0, 0));
    // A contact still held changes nothing; snapshot ends with and without changes.
    directed.push_back(mk_pair(1, 7, 8, EL_MN, EL_H, 0, 0, 0, 1));
    directed.push_back(mk_pair(1, 7, 8, EL_MN, EL_H, 0, 0, 0, 1));
    directed.push_back(mk_pair(2, 9, 10, EL_MN, EL_BR, 1, 0, 0, 1));
    foreach (directed[i]) begin
      send_pair(directed[i]);
    end
    drain();

    // Random phases, each with its own thresholds and a pool of pairs swept as snapshots.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      span   = spans[ph];
      steady = (ph == 1);
      lim    = 3 * longint'(span) * longint'(span);
      if (lim > (2 ** THR_W) - 1) begin
        lim = (2 ** THR_W) - 1;
      end
      for (int r = 0; r < NUM_REGS; r++) begin
        if (ph == 0) begin
          vals[r] = '0;
        end else if (ph == 1) begin
          vals[r] = '1;
        end else begin
          vals[r] = {THR_W'($urandom_range(0, int'(lim))), THR_W'($urandom_range(0, int'(lim)))};
        end
      end

      // Thresholds are written while nothing is in flight.
      for (int r = 0; r < NUM_REGS; r++) begin
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= REG_IDX_W'(r);
        cfg_if.wdata     <= vals[r];
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        sb.set_threshold(r, vals[r]);
      end
      cfg_if.valid <= 1'b0;

      // A pool of pairs, mostly with listed element pairs.
      pool_size = $urandom_range(4, 24);
      for (int k = 0; k < pool_size; k++) begin
        sel = $urandom_range(0, 19);
        pool[k] = mk_pair(SLOT_IN_W'($urandom), ATOM_W'($urandom), ATOM_W'($urandom),
                          EL_MN, EL_C, 0, ($urandom_range(0, 15) == 0), 0, 0);
        if (sel < 17) begin
          pool[k].metal_elem = LISTED_METAL[sel % 9];
          pool[k].atom_elem  = LISTED_PARTNER[sel % 9];
        end else if (sel > 17) begin
          pool[k].metal_elem = ELEM_W'($urandom);
          pool[k].atom_elem  = ELEM_W'($urandom);
        end
        if ($urandom_range(0, 15) == 0) begin
          pool[k].atom_index = pool[k].metal_atom_index;
        end
      end

      // Sweep the pool with fresh offsets; some sweeps are cut short, noise is mixed in.
      first       = (ph == 0) || ($urandom_range(0, 1) == 1);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, pool_size - 1) : pool_size;
        for (int k = 0; k < cut; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            p = mk_pair(SLOT_IN_W'($urandom), ATOM_W'($urandom), ATOM_W'($urandom),
                        ELEM_W'($urandom), ELEM_W'($urandom), DELTA_W'($urandom),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        ($urandom_range(0, 7) == 0));
            p.delta_y = DELTA_W'($urandom);
            p.delta_z = DELTA_W'($urandom);
            send_pair(p);
            phase_items++;
          end
          if ($urandom_range(0, 23) == 0) begin
            pool[k].cov_bonded = !pool[k].cov_bonded;
          end
          p                = pool[k];
          p.delta_x        = rand_delta(span);
          p.delta_y        = rand_delta(span);
          p.delta_z        = rand_delta(span);
          p.first_snapshot = first;
          p.last_pair      = (k == pool_size - 1);
          send_pair(p);
          phase_items++;
        end
        first = 1'b0;
      end
      drain();
    end

    steady = 1'b0;
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS metal_contact_tracker");
    end else begin
      $display("FAIL metal_contact_tracker");
    end
    $finish;
  end

endmodule
